@@ src/ist_pkg.sv @@
// ist_pkg: shared types and constants for the integer set table
// request kinds, status codes, field widths and controller/datapath structs
// no dependencies
`default_nettype none

package ist_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int SPREAD_W = 33;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPREAD = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FALSE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ist_cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
	} ist_sts_t;

endpackage

`default_nettype wire

@@ src/ist_ctrl.sv @@
// ist_ctrl: request sequencer for the integer set table
// steps through accept, slot scan, drain and commit; uses ist_pkg
`default_nettype none

module ist_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ist_pkg::ist_sts_t sts,
	output ist_pkg::ist_cmd_t      cmd
);
	import ist_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

@@ src/ist_dp.sv @@
// ist_dp: datapath of the integer set table
// element memory, valid bits, member count, scan compare stage and result register
// uses ist_pkg
`default_nettype none

module ist_dp #(
	parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ist_pkg::ist_cmd_t                    cmd,
	output ist_pkg::ist_sts_t                         sts,
	input  wire logic        [ist_pkg::KIND_W-1:0]    kind,
	input  wire logic signed [ist_pkg::VALUE_W-1:0]   value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic             [ist_pkg::STATUS_W-1:0]  status,
	output logic             [ist_pkg::COUNT_W-1:0]   member_count,
	output logic                                      is_empty,
	output logic signed      [ist_pkg::SPREAD_W-1:0]  spread
);
	import ist_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	// element store
	logic signed [VALUE_W-1:0] mem [CAPACITY];
	logic [CAPACITY-1:0]       valid_q;
	logic [CNT_W-1:0]          cnt_q;

	// request registers
	logic [KIND_W-1:0]         kind_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [IDX_W-1:0]          idx_q;

	// read stage
	logic                      act_s1;
	logic                      vld_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic signed [VALUE_W-1:0] rd_s1;

	// scan results
	logic                      found_q;
	logic [IDX_W-1:0]          fidx_q;
	logic                      free_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic                      any_q;
	logic signed [VALUE_W-1:0] lo_q;
	logic signed [VALUE_W-1:0] hi_q;

	// result register
	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [COUNT_W-1:0]        count_out_q;
	logic                      empty_q;
	logic signed [SPREAD_W-1:0] spread_q;

	logic [STATUS_W-1:0]       status_nxt;
	logic [CNT_W-1:0]          cnt_nxt;
	logic [CNT_W+COUNT_W-1:0]  cnt_ext;
	logic signed [SPREAD_W-1:0] spread_nxt;
	logic signed [SPREAD_W-1:0] diff;
	logic                      do_insert;
	logic                      do_remove;

	assign sts.last     = (idx_q == LAST_IDX);
	assign sts.out_busy = out_valid_q && out_stall;

	assign diff = SPREAD_W'(hi_q) - SPREAD_W'(lo_q);

	always_comb begin
		status_nxt = STATUS_OK;
		spread_nxt = '0;
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		cnt_nxt    = cnt_q;
		case (kind_q)
			KIND_INSERT: begin
				if (found_q) begin
					status_nxt = STATUS_FALSE;
				end else if (!free_q) begin
					status_nxt = STATUS_FULL;
				end else begin
					do_insert = 1'b1;
					cnt_nxt   = cnt_q + CNT_W'(1);
				end
			end
			KIND_REMOVE: begin
				if (found_q) begin
					do_remove = 1'b1;
					if (cnt_q != '0) begin
						cnt_nxt = cnt_q - CNT_W'(1);
					end
				end else begin
					status_nxt = STATUS_FALSE;
				end
			end
			KIND_LOOKUP: begin
				status_nxt = found_q ? STATUS_OK : STATUS_FALSE;
			end
			default: begin
				spread_nxt = any_q ? diff : '1;
			end
		endcase
	end

	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

	// memory: one read per scan cycle, at most one write at commit for an insert
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_s1 <= mem[idx_q];
		end
		if (cmd.commit && do_insert) begin
			mem[free_idx_q] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			val_q  <= value;
		end
		vld_s1 <= valid_q[idx_q];
		idx_s1 <= idx_q;
		if (act_s1 && vld_s1) begin
			if (!any_q || rd_s1 < lo_q) begin
				lo_q <= rd_s1;
			end
			if (!any_q || rd_s1 > hi_q) begin
				hi_q <= rd_s1;
			end
		end
		if (act_s1 && vld_s1 && rd_s1 == val_q) begin
			fidx_q <= idx_s1;
		end
		if (act_s1 && !vld_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.commit) begin
			status_q    <= status_nxt;
			count_out_q <= cnt_ext[COUNT_W-1:0];
			empty_q     <= (cnt_nxt == '0);
			spread_q    <= spread_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			act_s1      <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			act_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
				any_q   <= 1'b0;
			end else begin
				if (cmd.scan) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (act_s1 && vld_s1) begin
					any_q <= 1'b1;
					if (rd_s1 == val_q) begin
						found_q <= 1'b1;
					end
				end
				if (act_s1 && !vld_s1) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				cnt_q <= cnt_nxt;
				if (do_insert) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (do_remove) begin
					valid_q[fidx_q] <= 1'b0;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign member_count = count_out_q;
	assign is_empty     = empty_q;
	assign spread       = spread_q;

endmodule

`default_nettype wire

@@ src/integer_set_table.sv @@
// integer_set_table: fixed-capacity set of signed 32-bit values
// top level joining ist_ctrl and ist_dp; uses ist_pkg
//
// input channel: in_valid/in_stall with kind (insert, remove, lookup, spread)
// and value; a transfer happens when in_valid is high and in_stall is low
// output channel: out_valid/out_stall with status, member_count, is_empty and
// spread; exactly one result per request, in request order
// every request scans all CAPACITY slots, one memory read per cycle, then
// passes through a drain state and a commit state after its accept state;
// the request rate is set by the single read port of the element memory
// the result is held in an output register; the next request is taken while
// that result waits, and a request only stalls at its commit when the
// previous result is still held by out_stall
// reset clears all valid bits, the member count and both channels at once;
// no clearing pass is needed, the element memory is read only under valid bits
`default_nettype none

module integer_set_table #(
	parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [ist_pkg::KIND_W-1:0]    kind,
	input  wire logic signed [ist_pkg::VALUE_W-1:0]   value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic             [ist_pkg::STATUS_W-1:0]  status,
	output logic             [ist_pkg::COUNT_W-1:0]   member_count,
	output logic                                      is_empty,
	output logic signed      [ist_pkg::SPREAD_W-1:0]  spread
);
	import ist_pkg::*;

	ist_cmd_t cmd;
	ist_sts_t sts;

	ist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ist_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.member_count (member_count),
		.is_empty     (is_empty),
		.spread       (spread)
	);

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for integer_set_table: a directed table, then random request phases
// that grow, shrink and mix the set, checked against typed rows or a local model
// depends on ist_pkg and integer_set_table
module testbench;
	import ist_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 1330;

	localparam logic signed [VALUE_W-1:0]  VALUE_MIN   = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0]  VALUE_MAX   = 32'sh7FFF_FFFF;
	localparam logic        [SPREAD_W-1:0] SPREAD_NONE = '1;
	localparam logic        [SPREAD_W-1:0] SPREAD_FULL = 33'h0_FFFF_FFFF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic                empty;
		logic [SPREAD_W-1:0] spread;
	} set_reply_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               typed;
		set_reply_t         reply;
	} stim_row_t;

	typedef enum {MIX_OPS, GROW_SET, SHRINK_SET} traffic_mode_t;

	localparam set_reply_t NO_REPLY = '0;

	localparam stim_row_t DIRECTED [0:22] = '{
		'{KIND_SPREAD, 32'd0,       1'b1, '{STATUS_OK,    7'd0, 1'b1, SPREAD_NONE}},
		'{KIND_LOOKUP, 32'd0,       1'b1, '{STATUS_FALSE, 7'd0, 1'b1, 33'd0}},
		'{KIND_REMOVE, 32'd5,       1'b1, '{STATUS_FALSE, 7'd0, 1'b1, 33'd0}},
		'{KIND_INSERT, VALUE_MIN,   1'b1, '{STATUS_OK,    7'd1, 1'b0, 33'd0}},
		'{KIND_INSERT, VALUE_MAX,   1'b1, '{STATUS_OK,    7'd2, 1'b0, 33'd0}},
		'{KIND_SPREAD, 32'd0,       1'b1, '{STATUS_OK,    7'd2, 1'b0, SPREAD_FULL}},
		'{KIND_INSERT, VALUE_MAX,   1'b1, '{STATUS_FALSE, 7'd2, 1'b0, 33'd0}},
		'{KIND_LOOKUP, VALUE_MIN,   1'b1, '{STATUS_OK,    7'd2, 1'b0, 33'd0}},
		'{KIND_LOOKUP, 32'd0,       1'b1, '{STATUS_FALSE, 7'd2, 1'b0, 33'd0}},
		'{KIND_INSERT, 32'd0,       1'b0, NO_REPLY},
		'{KIND_INSERT, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
		'{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
		'{KIND_SPREAD, 32'h5A5A_5A5A, 1'b0, NO_REPLY},
		'{KIND_REMOVE, VALUE_MAX,   1'b1, '{STATUS_OK,    7'd3, 1'b0, 33'd0}},
		'{KIND_REMOVE, VALUE_MAX,   1'b1, '{STATUS_FALSE, 7'd3, 1'b0, 33'd0}},
		'{KIND_REMOVE, 32'd0,       1'b0, NO_REPLY},
		'{KIND_REMOVE, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
		'{KIND_SPREAD, 32'd0,       1'b1, '{STATUS_OK,    7'd1, 1'b0, 33'd0}},
		'{KIND_INSERT, VALUE_MAX,   1'b0, NO_REPLY},
		'{KIND_REMOVE, VALUE_MIN,   1'b0, NO_REPLY},
		'{KIND_REMOVE, VALUE_MAX,   1'b1, '{STATUS_OK,    7'd0, 1'b1, 33'd0}},
		'{KIND_SPREAD, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,  7'd0, 1'b1, SPREAD_NONE}},
		'{KIND_LOOKUP, VALUE_MAX,   1'b1, '{STATUS_FALSE, 7'd0, 1'b1, 33'd0}}
	};

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic        [KIND_W-1:0]    kind      = KIND_INSERT;
	logic signed [VALUE_W-1:0]   value     = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic        [STATUS_W-1:0]  status;
	logic        [COUNT_W-1:0]   member_count;
	logic                        is_empty;
	logic signed [SPREAD_W-1:0]  spread;

	logic signed [VALUE_W-1:0] member_val  [CAPACITY_DEF];
	bit                        member_live [CAPACITY_DEF];
	int                        member_total = 0;

	set_reply_t pending_replies [$];
	int         fail_count = 0;
	int         idle_cycles = 0;
	int         stall_left = 0;
	int         run_left = 0;

	integer_set_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.member_count (member_count),
		.is_empty     (is_empty),
		.spread       (spread)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic set_reply_t apply_request(input logic [KIND_W-1:0] k,
		input logic signed [VALUE_W-1:0] v);
		set_reply_t r;
		int         hit;
		int         free_slot;
		longint     lo;
		longint     hi;
		bit         any;
		r = NO_REPLY;
		r.status = STATUS_OK;
		hit = -1;
		free_slot = -1;
		lo = 0;
		hi = 0;
		any = 1'b0;
		for (int i = 0; i < CAPACITY_DEF; i++) begin
			if (member_live[i] && member_val[i] == v && hit < 0)
				hit = i;
			if (!member_live[i] && free_slot < 0)
				free_slot = i;
		end
		case (k)
			KIND_INSERT: begin
				if (hit >= 0)
					r.status = STATUS_FALSE;
				else if (free_slot < 0)
					r.status = STATUS_FULL;
				else begin
					member_val[free_slot] = v;
					member_live[free_slot] = 1'b1;
					member_total++;
				end
			end
			KIND_REMOVE: begin
				if (hit < 0)
					r.status = STATUS_FALSE;
				else begin
					member_live[hit] = 1'b0;
					member_total--;
				end
			end
			KIND_LOOKUP: begin
				r.status = (hit >= 0) ? STATUS_OK : STATUS_FALSE;
			end
			default: begin
				for (int i = 0; i < CAPACITY_DEF; i++) begin
					if (member_live[i]) begin
						if (!any || longint'(member_val[i]) < lo)
							lo = member_val[i];
						if (!any || longint'(member_val[i]) > hi)
							hi = member_val[i];
						any = 1'b1;
					end
				end
				r.spread = any ? SPREAD_W'(hi - lo) : SPREAD_NONE;
			end
		endcase
		r.count = COUNT_W'(member_total);
		r.empty = (member_total == 0);
		return r;
	endfunction

	// member_pct: chance of reusing a value already in the set
	function automatic logic [VALUE_W-1:0] draw_value(input int member_pct);
		int r;
		int start;
		r = $urandom_range(0, 99);
		start = $urandom_range(0, CAPACITY_DEF - 1);
		if (r < member_pct && member_total > 0) begin
			for (int j = 0; j < CAPACITY_DEF; j++)
				if (member_live[(start + j) % CAPACITY_DEF])
					return member_val[(start + j) % CAPACITY_DEF];
		end
		r = $urandom_range(0, 99);
		if (r < 30)
			return VALUE_W'($urandom_range(0, 16) - 8);
		if (r < 40) begin
			case ($urandom_range(0, 3))
				0: return VALUE_MIN;
				1: return VALUE_MAX;
				2: return VALUE_MIN + 1;
				default: return VALUE_MAX - 1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic push_request(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
		input logic typed, input set_reply_t typed_reply);
		set_reply_t predicted;
		@(negedge clk);
		in_valid = 1'b1;
		kind = k;
		value = v;
		do
			@(posedge clk);
		while (in_stall);
		predicted = apply_request(k, v);
		pending_replies.push_back(typed ? typed_reply : predicted);
	endtask

	task automatic drain_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// receiver stall pattern, with calm stretches
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (run_left > 0) begin
			out_stall = 1'b0;
			run_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			run_left = $urandom_range(100, 400);
		end else begin
			stall_left = $urandom_range(1, 90);
			run_left = $urandom_range(0, 60);
		end
	end

	always @(posedge clk) begin
		set_reply_t got;
		set_reply_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("integer_set_table test failed");
				$finish;
			end
			if (out_valid && !out_stall) begin
				got = '{status, member_count, is_empty, spread};
				if (pending_replies.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer: status %0d count %0d empty %0d spread %h",
							got.status, got.count, got.empty, got.spread);
				end else begin
					want = pending_replies.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected status %0d count %0d empty %0d spread %h, got status %0d count %0d empty %0d spread %h",
								want.status, want.count, want.empty, want.spread,
								got.status, got.count, got.empty, got.spread);
					end
				end
			end
		end
	end

	initial begin
		traffic_mode_t         mode;
		int                    phase_left;
		int                    burst_left;
		int                    gap;
		int                    random_sent;
		int                    r;
		int                    member_pct;
		logic [KIND_W-1:0]     k;
		for (int i = 0; i < CAPACITY_DEF; i++) begin
			member_val[i] = '0;
			member_live[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			push_request(DIRECTED[i].kind, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].reply);
		drain_replies();

		mode = MIX_OPS;
		phase_left = 0;
		burst_left = $urandom_range(1, 24);
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				r = $urandom_range(0, 9);
				mode = (r < 4) ? GROW_SET : (r < 7) ? SHRINK_SET : MIX_OPS;
				phase_left = (mode == GROW_SET) ? $urandom_range(60, 160) : $urandom_range(20, 100);
				if ($urandom_range(0, 4) == 0)
					drain_replies();
			end
			r = $urandom_range(0, 99);
			case (mode)
				GROW_SET: begin
					k = (r < 70) ? KIND_INSERT : (r < 80) ? KIND_LOOKUP :
						(r < 90) ? KIND_SPREAD : KIND_REMOVE;
					member_pct = 10;
				end
				SHRINK_SET: begin
					k = (r < 70) ? KIND_REMOVE : (r < 80) ? KIND_LOOKUP :
						(r < 90) ? KIND_SPREAD : KIND_INSERT;
					member_pct = 75;
				end
				default: begin
					k = KIND_W'($urandom_range(0, 3));
					member_pct = 35;
				end
			endcase
			push_request(k, draw_value(member_pct), 1'b0, NO_REPLY);
			random_sent++;
			phase_left--;
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				r = $urandom_range(0, 99);
				gap = (r < 20) ? 0 : (r < 70) ? $urandom_range(1, 6) : $urandom_range(7, 75);
				if (gap > 0) begin
					@(negedge clk);
					in_valid = 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain_replies();
		repeat (CAPACITY_DEF + 16) @(posedge clk);
		if (fail_count == 0 && pending_replies.size() == 0)
			$display("integer_set_table test passed");
		else
			$display("integer_set_table test failed");
		$finish;
	end

endmodule
